// ===== sv/ibnf_pkg.sv =====
// ----------------------------------------------------------------------------
// ibnf_pkg: shared constants and types of the identifier bitmap search
// Sizes of the used map, request codes and the command and status groups
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ibnf_pkg;

  localparam int ID_SPACE  = 1024;
  localparam int NUM_TYPES = 8;

  // Field widths of the request and result words.
  localparam int REQ_W  = 3;
  localparam int TYPE_W = 3;
  localparam int NUM_W  = 10;

  // The map is stored as words; a region holds a whole number of words.
  localparam int WORD_W    = (ID_SPACE < 32) ? ID_SPACE : 32;
  localparam int WPR       = ID_SPACE / WORD_W;
  localparam int NUM_WORDS = NUM_TYPES * WPR;

  localparam int IDX_W  = $clog2(ID_SPACE);
  localparam int OFF_W  = $clog2(WORD_W);
  localparam int WIDX_W = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int TIDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int ADDR_W = TIDX_W + WIDX_W;
  localparam int CNT_W  = WIDX_W + 1;

  // Request codes; codes above REQ_DOWN behave as a test.
  localparam logic [REQ_W-1:0] REQ_TEST  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SET   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd2;
  localparam logic [REQ_W-1:0] REQ_UP    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DOWN  = 3'd4;

  typedef struct packed {
    logic load;     // take the request word and read its first map word
    logic rd_next;  // move to the neighbor word and read it
    logic wr_en;    // write the modified word back
    logic finish;   // load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic type_ok;    // type selects an existing region
    logic search;     // request is an upward or downward search
    logic write_req;  // request is a set or a clear
    logic hit;        // the current word holds a free number in range
    logic last;       // the current word is the start word seen again
    logic out_free;   // result register can take a new word
  } dp_sts_t;

endpackage

// ===== sv/ibnf_if.sv =====
// ----------------------------------------------------------------------------
// ibnf_if: request and result channels of the identifier bitmap search
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ibnf_req_if;
  logic                        valid;
  logic                        ready;
  logic [ibnf_pkg::REQ_W-1:0]  req_type;
  logic [ibnf_pkg::TYPE_W-1:0] entry_type;
  logic [ibnf_pkg::NUM_W-1:0]  entry_number;

  modport source(output valid, output req_type, output entry_type, output entry_number,
                 input ready);
  modport sink(input valid, input req_type, input entry_type, input entry_number,
               output ready);
endinterface

interface ibnf_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       is_used;
  logic [ibnf_pkg::NUM_W-1:0] free_number;
  logic                       none_free;

  modport source(output valid, output is_used, output free_number, output none_free,
                 input ready);
  modport sink(input valid, input is_used, input free_number, input none_free,
               output ready);
endinterface

// ===== sv/ibnf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ibnf_ctrl: request sequencer of the identifier bitmap search
// Takes one request at a time and steps the datapath word by word.
// ----------------------------------------------------------------------------
module ibnf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ibnf_pkg::dp_sts_t sts,
  output ibnf_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   done;

  // The request is settled once the current word answers it.
  assign done = !sts.type_ok || !sts.search || sts.hit || sts.last;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (done) begin
          if (sts.out_free) begin
            cmd.finish = 1'b1;
            cmd.wr_en  = sts.type_ok && sts.write_req;
            state_nxt  = ST_IDLE;
          end
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/ibnf_dp.sv =====
// ----------------------------------------------------------------------------
// ibnf_dp: used-map memory, word scanner and result register
// Holds the map as words with one valid bit per word, finds the nearest
// free bit in a masked word and forms the result word.
// ----------------------------------------------------------------------------
module ibnf_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ibnf_pkg::dp_cmd_t           cmd,
  output ibnf_pkg::dp_sts_t           sts,
  input  logic [ibnf_pkg::REQ_W-1:0]  in_req_type,
  input  logic [ibnf_pkg::TYPE_W-1:0] in_entry_type,
  input  logic [ibnf_pkg::NUM_W-1:0]  in_entry_number,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_is_used,
  output logic [ibnf_pkg::NUM_W-1:0]  out_free_number,
  output logic                        out_none_free
);

  localparam int WORD_W = ibnf_pkg::WORD_W;
  localparam int OFF_W  = ibnf_pkg::OFF_W;
  localparam int WIDX_W = ibnf_pkg::WIDX_W;
  localparam int TIDX_W = ibnf_pkg::TIDX_W;
  localparam int ADDR_W = ibnf_pkg::ADDR_W;
  localparam int CNT_W  = ibnf_pkg::CNT_W;
  localparam int IDX_W  = ibnf_pkg::IDX_W;

  function automatic logic [OFF_W-1:0] lowest_one(input logic [WORD_W-1:0] v);
    logic [OFF_W-1:0] p;
    p = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) p = OFF_W'(i);
    end
    return p;
  endfunction

  function automatic logic [OFF_W-1:0] highest_one(input logic [WORD_W-1:0] v);
    logic [OFF_W-1:0] p;
    p = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) p = OFF_W'(i);
    end
    return p;
  endfunction

  // Map storage; a word whose valid bit is low reads as all free.
  logic [WORD_W-1:0]               mem [ibnf_pkg::NUM_WORDS];
  logic [ibnf_pkg::NUM_WORDS-1:0]  vld_r;
  logic [WORD_W-1:0]               rdata_r;
  logic                            rvld_r;

  // Request held for the whole scan.
  logic [ibnf_pkg::REQ_W-1:0]  req_r;
  logic [ibnf_pkg::TYPE_W-1:0] type_r;
  logic [IDX_W-1:0]            num_r;
  logic [WIDX_W-1:0]           widx_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        used_r;

  logic                        out_valid_r;
  logic                        out_is_used_r;
  logic [ibnf_pkg::NUM_W-1:0]  out_free_number_r;
  logic                        out_none_free_r;

  logic              search, up, type_ok, first, last, hit, cur_used, rd_en;
  logic [OFF_W-1:0]  off, pos;
  logic [WORD_W-1:0] word, ge_mask, gt_mask, mask, free_bits, wr_word;
  logic [WIDX_W-1:0] widx_step;
  logic [ADDR_W-1:0] rd_addr, wr_addr;

  assign search  = (req_r == ibnf_pkg::REQ_UP) || (req_r == ibnf_pkg::REQ_DOWN);
  assign up      = (req_r == ibnf_pkg::REQ_UP);
  assign type_ok = ({1'b0, type_r} < (ibnf_pkg::TYPE_W + 1)'(ibnf_pkg::NUM_TYPES));
  assign first   = (cnt_r == '0);
  assign last    = (cnt_r == CNT_W'(ibnf_pkg::WPR));
  assign word    = rvld_r ? rdata_r : '0;
  assign off     = num_r[OFF_W-1:0];

  // Bits at or above the start bit, and strictly above it.
  assign ge_mask = {WORD_W{1'b1}} << off;
  assign gt_mask = ge_mask << 1;

  // The start word is looked at twice: first on the start side of the bit,
  // then, after a full turn, on the other side.
  always_comb begin
    if (up) begin
      mask = first ? ge_mask : (last ? ~ge_mask : '1);
    end else begin
      mask = first ? ~gt_mask : (last ? gt_mask : '1);
    end
  end

  assign free_bits = ~word & mask;
  assign hit       = |free_bits;
  assign pos       = up ? lowest_one(free_bits) : highest_one(free_bits);
  assign cur_used  = first ? word[off] : used_r;
  assign widx_step = up ? widx_r + WIDX_W'(1) : widx_r - WIDX_W'(1);

  assign rd_en   = cmd.load || cmd.rd_next;
  assign rd_addr = cmd.load ? {in_entry_type[TIDX_W-1:0], in_entry_number[IDX_W-1:OFF_W]}
                            : {type_r[TIDX_W-1:0], widx_step};
  assign wr_addr = {type_r[TIDX_W-1:0], widx_r};

  always_comb begin
    wr_word      = word;
    wr_word[off] = (req_r == ibnf_pkg::REQ_SET);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
      rvld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      type_r <= in_entry_type;
      num_r  <= in_entry_number[IDX_W-1:0];
      widx_r <= in_entry_number[IDX_W-1:OFF_W];
      cnt_r  <= '0;
    end else if (cmd.rd_next) begin
      widx_r <= widx_step;
      cnt_r  <= cnt_r + CNT_W'(1);
      used_r <= cur_used;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_is_used_r     <= type_ok && cur_used;
      out_free_number_r <= (search && type_ok && hit) ? {widx_r, pos} : num_r;
      out_none_free_r   <= search && !(type_ok && hit);
    end
  end

  assign sts.type_ok   = type_ok;
  assign sts.search    = search;
  assign sts.write_req = (req_r == ibnf_pkg::REQ_SET) || (req_r == ibnf_pkg::REQ_CLEAR);
  assign sts.hit       = hit;
  assign sts.last      = last;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_is_used     = out_is_used_r;
  assign out_free_number = out_free_number_r;
  assign out_none_free   = out_none_free_r;

endmodule

// ===== sv/id_bitmap_next_free_search.sv =====
// ----------------------------------------------------------------------------
// id_bitmap_next_free_search: identifier used-map with next-free search
// A test, set or clear reads the map word of its bit and then loads its result
// word; a search also steps word by word round its region of 32 words, at most
// once round, the memory port reading one word a cycle. The next request is
// taken only after the result of the last one is loaded.
// Reset clears the control and the 256 per-word valid bits at once.
// ----------------------------------------------------------------------------
//
// The used map keeps one bit per identifier, one region of ID_SPACE bits per
// identifier type. It is held in a single memory of 32-bit words, one region
// being 32 consecutive words. Every memory word has a valid flop; a word that
// was never written reads as all zeros, so the map is all free right after
// reset without any clearing pass.
//
// The controller takes one request word at a time. On accept the datapath
// reads the word that holds the requested bit. In the next cycle the word is
// checked:
//   - test, set and clear report the old bit; set and clear write the word
//     back with the bit changed, and the result word is loaded;
//   - a search masks the start word to the bits on the search side of the
//     start bit and picks the nearest free bit. Without a hit it steps to the
//     next or previous word of the region, wrapping at the region ends, one
//     word per cycle. After a full turn the start word is checked again on
//     the other side of the start bit; if that also fails, none_free is set
//     and the start number is returned.
// A type that names no region changes nothing and reports is_used low.
//
// The result register sits between the scanner and the result channel, so a
// new request is taken while an earlier result word still waits; the scan
// only holds in its final cycle if the result register is still occupied.
module id_bitmap_next_free_search (
  input  logic       clk,
  input  logic       rst_n,
  ibnf_req_if.sink   in_ch,
  ibnf_rsp_if.source out_ch
);

  ibnf_pkg::dp_cmd_t cmd;
  ibnf_pkg::dp_sts_t sts;

  ibnf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ibnf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_ch.req_type),
    .in_entry_type   (in_ch.entry_type),
    .in_entry_number (in_ch.entry_number),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_is_used     (out_ch.is_used),
    .out_free_number (out_ch.free_number),
    .out_none_free   (out_ch.none_free)
  );

endmodule

// ===== sv/ibnf_chk.sv =====
// ----------------------------------------------------------------------------
// ibnf_chk: port-level checks of the identifier bitmap search
// Tracks words in flight from accept to delivery and checks the result port.
// ----------------------------------------------------------------------------
module ibnf_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_is_used,
  input logic [ibnf_pkg::NUM_W-1:0] out_free_number,
  input logic                       out_none_free
);

  logic [1:0] pend_r;
  logic [1:0] pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) pend_nxt = pend_r + 2'd1;
    if (out_acc && !in_acc) pend_nxt = pend_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A waiting result word holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_is_used) &&
      $stable(out_free_number) && $stable(out_none_free))
    else $error("result word changed while stalled");

  // At most one request is scanned while one result waits.
  a_in_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pend_r < 2'd2)
    else $error("request taken with two words already in flight");

  // Every result word belongs to an accepted request.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result word without a pending request");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind id_bitmap_next_free_search ibnf_chk u_ibnf_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_is_used     (out_ch.is_used),
  .out_free_number (out_ch.free_number),
  .out_none_free   (out_ch.none_free)
);
